[src/pac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg: shared widths, types and constants for the polygon area block
// Field widths of the vertex and result beats, multiplier operand sizes and
// the widths used by the serial centroid divider.
// ----------------------------------------------------------------------------
package pac_pkg;

	// beat field widths
	localparam int XY_W   = 16;
	localparam int AREA_W = 43;
	localparam int MOM_W  = 59;
	localparam int CEN_W  = 20;
	localparam int FRAC_W = 4;

	// shared multiplier: 18 x 34 signed covers both 16 x 16 cross terms
	// and the 17-bit coordinate sum times the 33-bit cross product
	localparam int MUL_A_W = XY_W + 2;
	localparam int MUL_B_W = 2 * XY_W + 2;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int TERM_W  = 2 * XY_W;
	localparam int C_W     = 2 * XY_W + 1;
	localparam int SUM_W   = XY_W + 1;

	// divider: one guard quotient bit above the 21-bit magnitude
	localparam int QUO_W  = CEN_W + 2;
	localparam int DIV_W  = AREA_W + 2 + QUO_W - 1;
	localparam int STEP_W = $clog2(QUO_W);

	// centroid limits
	localparam logic [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
	localparam logic [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};
	localparam logic [CEN_W:0]   MAG_POS_LIM = {2'b00, {(CEN_W-1){1'b1}}};
	localparam logic [CEN_W:0]   MAG_NEG_LIM = {2'b01, {(CEN_W-1){1'b0}}};

	typedef logic signed [XY_W-1:0]   coord_t;
	typedef logic signed [AREA_W-1:0] area_t;
	typedef logic signed [MOM_W-1:0]  moment_t;
	typedef logic signed [CEN_W-1:0]  centroid_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[src/pac_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_div: serial centroid divider
// Computes 16*|moment| / (3*|area|) by restoring shift-subtract, one quotient
// bit per cycle, then applies the sign and saturates to the centroid range.
// ----------------------------------------------------------------------------
module pac_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pac_pkg::moment_t    moment,
	input  pac_pkg::area_t      area,
	output pac_pkg::div_stat_t  stat,
	output pac_pkg::centroid_t  result
);
	import pac_pkg::*;

	logic [MOM_W-1:0]  mom_mag;
	logic [AREA_W-1:0] area_mag;
	logic [AREA_W+1:0] den3;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              fin_q;
	logic              neg_q;
	logic              ge;
	logic              sat;
	logic [CEN_W:0]    mag;
	logic [CEN_W:0]    neg_mag;

	// operand magnitudes and scaled denominator
	assign mom_mag  = moment[MOM_W-1] ? (~moment + 1'b1) : moment;
	assign area_mag = area[AREA_W-1] ? (~area + 1'b1) : area;
	assign den3     = {1'b0, area_mag, 1'b0} + {2'b00, area_mag};

	assign ge = (rem_q >= den_q);

	// control: step counter and finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// datapath: remainder, shifted divisor, quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DIV_W-MOM_W-FRAC_W){1'b0}}, mom_mag, {FRAC_W{1'b0}}};
			den_q <= {den3, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
			neg_q <= moment[MOM_W-1] ^ area[AREA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? (rem_q - den_q) : rem_q;
			den_q <= den_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	// sign and saturation
	assign sat     = quo_q[QUO_W-1];
	assign mag     = quo_q[CEN_W:0];
	assign neg_mag = ~mag + 1'b1;

	always_comb begin
		if (neg_q) begin
			result = (sat || (mag > MAG_NEG_LIM)) ? CEN_MIN : neg_mag[CEN_W-1:0];
		end else begin
			result = (sat || (mag > MAG_POS_LIM)) ? CEN_MAX : mag[CEN_W-1:0];
		end
	end

	assign stat.busy = busy_q | fin_q;
	assign stat.done = fin_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !(busy_q || fin_q))
		else $error("divider started while busy");

	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> $past(busy_q && (step_q == '0)))
		else $error("divider finished without last step");

	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> !fin_q)
		else $error("divider done longer than one cycle");

endmodule

[src/polygon_area_centroid_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_centroid_core: shoelace area, moments and centroid
// Accumulates one polygon vertex per beat and emits one result beat on the
// vertex marked last.
// ----------------------------------------------------------------------------
// Vertices come in order, one per beat; the beat with last_vertex set closes
// the polygon back to the first vertex and produces one result beat holding
// twice the signed area, six times both static moments (exact), the centroid
// with four fraction bits (truncated toward zero, saturated; zero with
// degenerate set when the area is zero), the y range and an overflow flag for
// polygons longer than MAX_VERTICES (extra vertices are dropped). Each edge
// runs four products through one shared 18 x 34 multiplier, so a vertex that
// adds an edge holds stall through states P1, P2, CR, P3, P4 and AC; one that
// adds none and is not last does not stall. A last vertex with an edge of its
// own holds stall through that edge, the closing edge, two serial divisions
// (start, 22 quotient bits one per cycle, finish) and the result load, which
// waits while a held result beat is stalled; the divisions are skipped when
// the area is zero, and a last vertex with no edge of its own runs only the
// closing edge. A new polygon may start while a result beat waits.
// ----------------------------------------------------------------------------
module polygon_area_centroid_core #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vertex_valid,
	output logic                vertex_stall,
	input  pac_pkg::coord_t     vertex_x,
	input  pac_pkg::coord_t     vertex_y,
	input  logic                last_vertex,
	output logic                result_valid,
	input  logic                result_stall,
	output pac_pkg::area_t      twice_area,
	output pac_pkg::moment_t    six_moment_about_x,
	output pac_pkg::moment_t    six_moment_about_y,
	output pac_pkg::centroid_t  centroid_x,
	output pac_pkg::centroid_t  centroid_y,
	output pac_pkg::coord_t     lowest_y,
	output pac_pkg::coord_t     highest_y,
	output logic [pac_pkg::XY_W-1:0] section_height,
	output logic                degenerate,
	output logic                too_many
);
	import pac_pkg::*;

	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int STATE_W = 4;

	localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
	localparam logic [STATE_W-1:0] S_P1     = 4'd1;
	localparam logic [STATE_W-1:0] S_P2     = 4'd2;
	localparam logic [STATE_W-1:0] S_CR     = 4'd3;
	localparam logic [STATE_W-1:0] S_P3     = 4'd4;
	localparam logic [STATE_W-1:0] S_P4     = 4'd5;
	localparam logic [STATE_W-1:0] S_AC     = 4'd6;
	localparam logic [STATE_W-1:0] S_DSTART = 4'd7;
	localparam logic [STATE_W-1:0] S_DWAIT  = 4'd8;
	localparam logic [STATE_W-1:0] S_OUT    = 4'd9;

	logic [STATE_W-1:0] state_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic               last_q;
	logic               close_q;
	logic               pass_q;
	coord_t             first_x_q, first_y_q, prev_x_q, prev_y_q;
	coord_t             min_y_q, max_y_q;
	area_t              area_q;
	moment_t            mx_q, my_q;

	// edge operands and multiplier pipeline
	coord_t                    ex0_q, ey0_q, ex1_q, ey1_q;
	logic signed [SUM_W-1:0]   sx_q, sy_q;
	logic signed [TERM_W-1:0]  t_q;
	logic signed [C_W-1:0]     c_q;
	logic signed [C_W-1:0]     c_next;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	centroid_t                 cx_q, cy_q;

	// result beat registers
	logic         res_valid_q;
	area_t        res_area_q;
	moment_t      res_mx_q, res_my_q;
	centroid_t    res_cx_q, res_cy_q;
	coord_t       res_lo_q, res_hi_q;
	logic [XY_W-1:0] res_ht_q;
	logic         res_deg_q, res_ovf_q;

	logic        accept;
	logic        drop;
	logic        first_v;
	logic        do_edge;
	logic        out_free;
	logic        div_start;
	moment_t     div_moment;
	div_stat_t   div_stat;
	centroid_t   div_result;

	assign vertex_stall = (state_q != S_IDLE);
	assign accept       = vertex_valid && (state_q == S_IDLE);
	assign drop         = (count_q >= CNT_W'(MAX_VERTICES));
	assign first_v      = (count_q == '0);
	assign do_edge      = !drop && !first_v;
	assign out_free     = !res_valid_q || !result_stall;

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_P1: begin
				mul_a = MUL_A_W'(ex0_q);
				mul_b = MUL_B_W'(ey1_q);
			end
			S_P2: begin
				mul_a = MUL_A_W'(ex1_q);
				mul_b = MUL_B_W'(ey0_q);
			end
			S_P3: begin
				mul_a = MUL_A_W'(sy_q);
				mul_b = MUL_B_W'(c_q);
			end
			S_P4: begin
				mul_a = MUL_A_W'(sx_q);
				mul_b = MUL_B_W'(c_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// cross product from the two registered terms
	assign c_next = C_W'(t_q) - $signed(prod_q[C_W-1:0]);

	// multiplier pipeline and edge operands
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_P1) begin
			sx_q <= SUM_W'(ex0_q) + SUM_W'(ex1_q);
			sy_q <= SUM_W'(ey0_q) + SUM_W'(ey1_q);
		end
		if (state_q == S_P2) begin
			t_q <= prod_q[TERM_W-1:0];
		end
		if (state_q == S_CR) begin
			c_q <= c_next;
		end
		if (accept) begin
			if (do_edge) begin
				ex0_q <= prev_x_q;
				ey0_q <= prev_y_q;
				ex1_q <= vertex_x;
				ey1_q <= vertex_y;
			end else begin
				ex0_q <= drop ? prev_x_q : vertex_x;
				ey0_q <= drop ? prev_y_q : vertex_y;
				ex1_q <= first_v ? vertex_x : first_x_q;
				ey1_q <= first_v ? vertex_y : first_y_q;
			end
		end else if ((state_q == S_AC) && last_q && !close_q) begin
			ex0_q <= prev_x_q;
			ey0_q <= prev_y_q;
			ex1_q <= first_x_q;
			ey1_q <= first_y_q;
		end
	end

	// sequencer, vertex bookkeeping and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			close_q   <= 1'b0;
			pass_q    <= 1'b0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			min_y_q   <= '0;
			max_y_q   <= '0;
			area_q    <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (drop) begin
							ovf_q <= 1'b1;
						end else begin
							if (first_v) begin
								first_x_q <= vertex_x;
								first_y_q <= vertex_y;
								min_y_q   <= vertex_y;
								max_y_q   <= vertex_y;
							end else begin
								if (vertex_y < min_y_q) min_y_q <= vertex_y;
								if (vertex_y > max_y_q) max_y_q <= vertex_y;
							end
							prev_x_q <= vertex_x;
							prev_y_q <= vertex_y;
							count_q  <= count_q + 1'b1;
						end
						last_q  <= last_vertex;
						close_q <= !do_edge;
						if (do_edge || last_vertex) begin
							state_q <= S_P1;
						end
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_CR;
				S_CR: begin
					area_q  <= area_q + AREA_W'(c_next);
					state_q <= S_P3;
				end
				S_P3: state_q <= S_P4;
				S_P4: begin
					mx_q    <= mx_q + MOM_W'(prod_q);
					state_q <= S_AC;
				end
				S_AC: begin
					my_q <= my_q + MOM_W'(prod_q);
					if (last_q && !close_q) begin
						close_q <= 1'b1;
						state_q <= S_P1;
					end else if (last_q) begin
						pass_q <= 1'b0;
						if (area_q == '0) begin
							cx_q    <= '0;
							cy_q    <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DSTART;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_stat.done) begin
						if (!pass_q) begin
							cx_q    <= div_result;
							pass_q  <= 1'b1;
							state_q <= S_DSTART;
						end else begin
							cy_q    <= div_result;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						count_q   <= '0;
						ovf_q     <= 1'b0;
						last_q    <= 1'b0;
						close_q   <= 1'b0;
						first_x_q <= '0;
						first_y_q <= '0;
						prev_x_q  <= '0;
						prev_y_q  <= '0;
						min_y_q   <= '0;
						max_y_q   <= '0;
						area_q    <= '0;
						mx_q      <= '0;
						my_q      <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// serial divider, shared by both centroid coordinates
	assign div_start  = (state_q == S_DSTART);
	assign div_moment = pass_q ? mx_q : my_q;

	pac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.moment (div_moment),
		.area   (area_q),
		.stat   (div_stat),
		.result (div_result)
	);

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			res_area_q <= area_q;
			res_mx_q   <= mx_q;
			res_my_q   <= my_q;
			res_cx_q   <= cx_q;
			res_cy_q   <= cy_q;
			res_lo_q   <= min_y_q;
			res_hi_q   <= max_y_q;
			res_ht_q   <= max_y_q - min_y_q;
			res_deg_q  <= (area_q == '0);
			res_ovf_q  <= ovf_q;
		end
	end

	assign result_valid       = res_valid_q;
	assign twice_area         = res_area_q;
	assign six_moment_about_x = res_mx_q;
	assign six_moment_about_y = res_my_q;
	assign centroid_x         = res_cx_q;
	assign centroid_y         = res_cy_q;
	assign lowest_y           = res_lo_q;
	assign highest_y          = res_hi_q;
	assign section_height     = res_ht_q;
	assign degenerate         = res_deg_q;
	assign too_many           = res_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond limit");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_deg_q) |-> ((res_cx_q == '0) && (res_cy_q == '0)))
		else $error("degenerate result with nonzero centroid");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_OUT))
		else $error("result beat raised outside output state");

	a_div_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (last_q && close_q && (area_q != '0)))
		else $error("division started without a closed polygon");

endmodule

[test/tb_polygon_area_centroid_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_area_centroid_core: self-checking bench for the polygon area core
// Streams polygons one vertex per beat: a table of hand-picked shapes first
// (single point, two points, collinear, 4 x 4 square, full-scale square and
// saturating bow ties), then random polygons under three stall patterns and a
// long receiver hold-off. A bit-true predictor builds each expected result
// beat (pinned rows carry their own) and every result beat is compared field
// by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module tb_polygon_area_centroid_core;
	import pac_pkg::*;

	localparam int MAX_V       = 1024;
	localparam int LONG_HOLD   = 600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_DIRECTED  = 22;

	typedef logic signed [63:0] wide_t;

	typedef enum int {FULL_RANGE, TINY_RANGE, RAIL_VALUES} coord_mode_e;

	typedef struct packed {
		area_t               twice_area;
		moment_t             six_mx;
		moment_t             six_my;
		centroid_t           cen_x;
		centroid_t           cen_y;
		coord_t              y_lo;
		coord_t              y_hi;
		logic [XY_W-1:0]     height;
		logic                degen;
		logic                over;
	} poly_result_t;

	typedef struct packed {
		coord_t       x;
		coord_t       y;
		logic         last;
		logic         pinned;
		poly_result_t res;
	} stim_row_t;

	// results that follow directly from the shape
	localparam poly_result_t LONE_POINT = '{43'sd0, 59'sd0, 59'sd0, 20'sd0, 20'sd0,
		-16'sd7, -16'sd7, 16'd0, 1'b1, 1'b0};
	localparam poly_result_t RAIL_PAIR = '{43'sd0, 59'sd0, 59'sd0, 20'sd0, 20'sd0,
		16'sh8000, 16'sh7fff, 16'hffff, 1'b1, 1'b0};
	localparam poly_result_t SQUARE_4 = '{43'sd32, 59'sd192, 59'sd192, 20'sd32, 20'sd32,
		16'sd0, 16'sd4, 16'd4, 1'b0, 1'b0};
	localparam poly_result_t DIAGONAL = '{43'sd0, 59'sd0, 59'sd0, 20'sd0, 20'sd0,
		16'sd0, 16'sd2, 16'd2, 1'b1, 1'b0};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       vertex_valid = 1'b0;
	logic       vertex_stall;
	coord_t     vertex_x = '0;
	coord_t     vertex_y = '0;
	logic       last_vertex = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	area_t      twice_area;
	moment_t    six_moment_about_x;
	moment_t    six_moment_about_y;
	centroid_t  centroid_x;
	centroid_t  centroid_y;
	coord_t     lowest_y;
	coord_t     highest_y;
	logic [XY_W-1:0] section_height;
	logic       degenerate;
	logic       too_many;

	// bench-side companions of the vertex beat
	logic       row_pinned = 1'b0;
	logic       hold_req = 1'b0;
	int         hold_count = 0;
	int         src_idle = 0;
	int         rcv_idle = 0;
	int         cycle_count = 0;
	int         errors = 0;

	poly_result_t result_q[$];
	poly_result_t pinned_q[$];
	stim_row_t    directed_rows [0:N_DIRECTED-1];

	// predictor state for the polygon being collected
	coord_t     poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
	coord_t     poly_lo_y, poly_hi_y;
	area_t      acc_area;
	moment_t    acc_mx, acc_my;
	int         poly_vertices;
	bit         poly_overflow;

	polygon_area_centroid_core #(.MAX_VERTICES(MAX_V)) i_dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_polygon_area_centroid_core: errors");
			$finish;
		end
	end

	// receiver stalls, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_req && hold_count < LONG_HOLD) begin
			result_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			result_stall <= ($urandom_range(99) < rcv_idle);
			if (!hold_req)
				hold_count <= 0;
		end
	end

	function automatic void clear_polygon();
		poly_first_x = '0;
		poly_first_y = '0;
		poly_prev_x = '0;
		poly_prev_y = '0;
		poly_lo_y = '0;
		poly_hi_y = '0;
		acc_area = '0;
		acc_mx = '0;
		acc_my = '0;
		poly_vertices = 0;
		poly_overflow = 1'b0;
	endfunction

	// one shoelace edge into the running sums
	function automatic void accumulate_edge(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		longint cp;
		cp = longint'(x0) * longint'(y1) - longint'(x1) * longint'(y0);
		acc_area = acc_area + cp;
		acc_mx = acc_mx + (longint'(y0) + longint'(y1)) * cp;
		acc_my = acc_my + (longint'(x0) + longint'(x1)) * cp;
	endfunction

	// 16 * moment / (3 * twice area), toward zero, clamped to the output range
	function automatic centroid_t centroid_of(moment_t mom, area_t area);
		longint      m;
		longint      a;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		bit          neg;
		m = mom;
		a = area;
		if (a == 0)
			return '0;
		num = (m < 0) ? -m : m;
		den = (a < 0) ? -a : a;
		q = (num * 64'd16) / (den * 64'd3);
		neg = (m < 0) != (a < 0);
		if (neg)
			return (q > 64'd524288) ? CEN_MIN : centroid_t'(~q + 64'd1);
		return (q > 64'd524287) ? CEN_MAX : centroid_t'(q);
	endfunction

	// fold one accepted vertex in; a last vertex closes the polygon
	task automatic predict_vertex(input coord_t x, input coord_t y, input logic last,
			output bit has_result, output poly_result_t r);
		has_result = 1'b0;
		r = '0;
		if (poly_vertices >= MAX_V) begin
			poly_overflow = 1'b1;
		end else begin
			if (poly_vertices == 0) begin
				poly_first_x = x;
				poly_first_y = y;
				poly_lo_y = y;
				poly_hi_y = y;
			end else begin
				accumulate_edge(poly_prev_x, poly_prev_y, x, y);
				if (y < poly_lo_y)
					poly_lo_y = y;
				if (y > poly_hi_y)
					poly_hi_y = y;
			end
			poly_prev_x = x;
			poly_prev_y = y;
			poly_vertices++;
		end
		if (last) begin
			accumulate_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
			r.twice_area = acc_area;
			r.six_mx = acc_mx;
			r.six_my = acc_my;
			r.cen_x = centroid_of(acc_my, acc_area);
			r.cen_y = centroid_of(acc_mx, acc_area);
			r.y_lo = poly_lo_y;
			r.y_hi = poly_hi_y;
			r.height = poly_hi_y - poly_lo_y;
			r.degen = (acc_area == 0);
			r.over = poly_overflow;
			has_result = 1'b1;
			clear_polygon();
		end
	endtask

	task automatic check_field(input string name, input wide_t want, input wide_t got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	initial clear_polygon();

	// vertex beats feed the predictor, result beats are checked in order
	always @(posedge clk) begin : track
		poly_result_t r;
		bit           has_r;
		if (arst_n && vertex_valid && !vertex_stall) begin
			predict_vertex(vertex_x, vertex_y, last_vertex, has_r, r);
			if (has_r) begin
				if (row_pinned)
					r = pinned_q.pop_front();
				result_q = {result_q, r};
			end
		end
		if (arst_n && result_valid && !result_stall) begin
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with no polygon pending", $time);
			end else begin
				r = result_q.pop_front();
				check_field("twice_area", $signed(r.twice_area), twice_area);
				check_field("six_moment_about_x", $signed(r.six_mx), six_moment_about_x);
				check_field("six_moment_about_y", $signed(r.six_my), six_moment_about_y);
				check_field("centroid_x", $signed(r.cen_x), centroid_x);
				check_field("centroid_y", $signed(r.cen_y), centroid_y);
				check_field("lowest_y", $signed(r.y_lo), lowest_y);
				check_field("highest_y", $signed(r.y_hi), highest_y);
				check_field("section_height", r.height, section_height);
				check_field("degenerate", r.degen, degenerate);
				check_field("too_many", r.over, too_many);
			end
		end
	end

	// drive one vertex beat, idling first at random, and wait for acceptance
	task automatic send_vertex(input coord_t x, input coord_t y, input logic last,
			input logic pinned);
		while ($urandom_range(99) < src_idle) begin
			vertex_valid <= 1'b0;
			@(negedge clk);
		end
		vertex_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= last;
		row_pinned <= pinned;
		@(posedge clk);
		while (vertex_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t pick_coord(coord_mode_e m);
		case (m)
			TINY_RANGE: return coord_t'($urandom_range(16) - 8);
			RAIL_VALUES: begin
				case ($urandom_range(5))
					0: return 16'sh8000;
					1: return 16'sh8001;
					2: return -16'sd1;
					3: return 16'sd0;
					4: return 16'sh7ffe;
					default: return 16'sh7fff;
				endcase
			end
			default: return coord_t'($urandom());
		endcase
	endfunction

	task automatic send_polygon(input int len, input coord_mode_e m);
		for (int k = 0; k < len; k++)
			send_vertex(pick_coord(m), pick_coord(m), k == len - 1, 1'b0);
	endtask

	// mostly 3 to 10 vertices, now and then a point or a pair
	task automatic random_polygons(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
			send_polygon(len, coord_mode_e'($urandom_range(2)));
			sent += len;
		end
	endtask

	// stop offering beats and wait for every pending result
	task automatic drain();
		vertex_valid <= 1'b0;
		while (result_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		directed_rows = '{
			// lone point
			'{16'sd5, -16'sd7, 1'b1, 1'b1, LONE_POINT},
			// two rail points, edges cancel
			'{16'sh8000, 16'sh7fff, 1'b0, 1'b0, '0},
			'{16'sh7fff, 16'sh8000, 1'b1, 1'b1, RAIL_PAIR},
			// 4 x 4 square, counterclockwise
			'{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd4, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd4, 16'sd4, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd4, 1'b1, 1'b1, SQUARE_4},
			// full-scale square
			'{16'sh8000, 16'sh8000, 1'b0, 1'b0, '0},
			'{16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0},
			'{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, '0},
			'{16'sh8000, 16'sh7fff, 1'b1, 1'b0, '0},
			// collinear points
			'{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd1, 16'sd1, 1'b0, 1'b0, '0},
			'{16'sd2, 16'sd2, 1'b1, 1'b1, DIAGONAL},
			// bow tie with tiny net area, centroid x clamps low
			'{-16'sd30000, -16'sd30000, 1'b0, 1'b0, '0},
			'{16'sd30000, 16'sd30000, 1'b0, 1'b0, '0},
			'{16'sd30000, -16'sd30000, 1'b0, 1'b0, '0},
			'{-16'sd30000, 16'sd30001, 1'b1, 1'b0, '0},
			// mirrored bow tie, centroid x clamps high
			'{16'sd30000, -16'sd30000, 1'b0, 1'b0, '0},
			'{-16'sd30000, 16'sd30000, 1'b0, 1'b0, '0},
			'{-16'sd30000, -16'sd30000, 1'b0, 1'b0, '0},
			'{16'sd30000, 16'sd30001, 1'b1, 1'b0, '0}
		};

		// reset
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed shapes, sender idles lightly, receiver heavily
		src_idle = 34;
		rcv_idle = 68;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].pinned)
				pinned_q = {pinned_q, directed_rows[i].res};
			send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
				directed_rows[i].pinned);
		end
		drain();
		random_polygons(180);
		drain();

		// sender idles heavily, receiver lightly
		src_idle = 68;
		rcv_idle = 34;
		random_polygons(180);
		drain();

		// no idling; long receiver hold-off while triangles keep coming
		src_idle = 0;
		rcv_idle = 0;
		hold_req <= 1'b1;
		repeat (12)
			send_polygon(3, FULL_RANGE);
		hold_req <= 1'b0;
		random_polygons(130);
		drain();
		repeat (100) @(negedge clk);

		if (errors == 0)
			$display("tb_polygon_area_centroid_core: clean");
		else
			$display("tb_polygon_area_centroid_core: errors");
		$finish;
	end

endmodule

[filelist.f]
src/pac_pkg.sv
src/pac_div.sv
src/polygon_area_centroid_core.sv
test/tb_polygon_area_centroid_core.sv
